[rtl/mpq_pkg.sv]
// ----------------------------------------------------------------------------
// mpq_pkg: shared types for the minimum priority queue
// Request and result words, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned OccW   = 5;

  // request kind
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } mpq_req_e;

  // result status
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } mpq_status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_MOVE,
    ST_RESP
  } mpq_state_e;

  // input word
  typedef struct packed {
    mpq_req_e                  req_type;
    logic signed [ValueW-1:0]  value;
  } mpq_in_t;

  // output word
  typedef struct packed {
    logic signed [ValueW-1:0]  removed_value;
    mpq_status_e               status;
    logic [OccW-1:0]           occupancy;
  } mpq_out_t;

endpackage

[rtl/min_priority_queue.sv]
// ----------------------------------------------------------------------------
// min_priority_queue: bounded minimum priority queue
// Unordered entry memory; delete-min scans all entries with one comparator.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-----------------------
//  in      | input     | in_valid_i / in_ready_o    | mpq_in_t  in_data_i
//  out     | output    | out_valid_o / out_ready_i  | mpq_out_t out_data_o
//
//  Insert, or delete on an empty queue: ST_RESP, then ready again in ST_IDLE.
//  Delete: ST_SCAN over all n entries, ST_LAST, ST_MOVE, ST_RESP; the scan
//  reads one entry per cycle into one signed comparator (single read port).
//  One request is in flight at a time; a new word is taken while the previous
//  result still sits in the output register.
//  Reset clears the fill count and the handshake state; memory needs no clear.
//  A stalled output holds the sequencer in its response state.
// ----------------------------------------------------------------------------
module min_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mpq_pkg::mpq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mpq_pkg::mpq_out_t out_data_o
);
  import mpq_pkg::*;

  localparam int unsigned AddrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);

  // entry memory
  logic signed [ValueW-1:0] mem_q [QUEUE_DEPTH];
  logic signed [ValueW-1:0] rdata_q;
  logic                     mem_we;
  logic [AddrW-1:0]         mem_waddr;
  logic [AddrW-1:0]         mem_raddr;
  logic signed [ValueW-1:0] mem_wdata;

  // sequencer and datapath registers
  mpq_state_e               st_q, st_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic [AddrW-1:0]         idx_q, idx_d;
  logic [AddrW-1:0]         pos_q, pos_d;
  logic signed [ValueW-1:0] best_q, best_d;
  mpq_out_t                 res_q, res_d;
  mpq_out_t                 out_q, out_d;
  logic                     out_valid_q, out_valid_d;

  logic [AddrW-1:0]         last_idx;
  logic                     is_full;

  assign last_idx = AddrW'(cnt_q - 1'b1);
  assign is_full  = (cnt_q == CntW'(QUEUE_DEPTH));

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    pos_q  <= pos_d;
    best_q <= best_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  // sequencer: next state, memory control and result
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    best_d      = best_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(cnt_q);
    mem_wdata   = in_data_i.value;
    mem_raddr   = '0;
    in_ready_o  = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d.removed_value = '0;
          res_d.status        = STATUS_OK;
          res_d.occupancy     = OccW'(cnt_q);
          if (in_data_i.req_type == REQ_INSERT) begin
            st_d = ST_RESP;
            if (is_full) begin
              res_d.status = STATUS_FULL;
            end else begin
              mem_we          = 1'b1;
              cnt_d           = cnt_q + 1'b1;
              res_d.occupancy = OccW'(cnt_d);
            end
          end else if (cnt_q == '0) begin
            res_d.status = STATUS_EMPTY;
            st_d         = ST_RESP;
          end else begin
            // start scan at entry 0
            idx_d = '0;
            st_d  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // rdata_q holds entry idx_q; fetch the next one
        mem_raddr = AddrW'(idx_q + 1'b1);
        if (idx_q == '0 || rdata_q < best_q) begin
          best_d = rdata_q;
          pos_d  = idx_q;
        end
        if (idx_q == last_idx) begin
          st_d = ST_LAST;
        end else begin
          idx_d = AddrW'(idx_q + 1'b1);
        end
      end

      ST_LAST: begin
        // fetch the tail entry to fill the hole
        mem_raddr = last_idx;
        st_d      = ST_MOVE;
      end

      ST_MOVE: begin
        mem_we              = 1'b1;
        mem_waddr           = pos_q;
        mem_wdata           = rdata_q;
        cnt_d               = cnt_q - 1'b1;
        res_d.removed_value = best_q;
        res_d.status        = STATUS_OK;
        res_d.occupancy     = OccW'(cnt_d);
        st_d                = ST_RESP;
      end

      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/mpq_checker.sv]
// ----------------------------------------------------------------------------
// mpq_checker: port-level checks for the minimum priority queue
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module mpq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input mpq_pkg::mpq_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mpq_pkg::mpq_out_t out_data_o
);
  import mpq_pkg::*;

  // a waiting request word holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // one request at a time: busy right after an accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while busy");

  // a dropped insert reports a full queue and no value
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_FULL |->
      out_data_o.occupancy == 5'(QUEUE_DEPTH) && out_data_o.removed_value == '0)
    else $error("full status with wrong occupancy or value");

  // delete on empty queue reports nothing stored
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_EMPTY |->
      out_data_o.occupancy == '0 && out_data_o.removed_value == '0)
    else $error("empty status with nonzero occupancy or value");

endmodule

bind min_priority_queue mpq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_mpq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
